// File: rtl/core/hamming96_bucket_screen_macros.svh
// Assertion macros used by the bucket screen checker.
`ifndef HAMMING96_BUCKET_SCREEN_MACROS_SVH
`define HAMMING96_BUCKET_SCREEN_MACROS_SVH

// Implication checked outside reset.
`define HB96S_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define HB96S_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define HB96S_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hb96s_pkg.sv
// Package: types, constants and helpers of the 96-bit bucket screen.
`timescale 1ns / 1ps
package hb96s_pkg;

  localparam int FRAME_W    = 96;
  localparam int POS_W      = 32;
  localparam int THR_W      = 7;
  localparam int DIST_W     = 7;
  localparam int CHUNK_W    = 8;
  localparam int N_CHUNKS   = FRAME_W / CHUNK_W;
  localparam int N_PAIRS    = N_CHUNKS / 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_CAND  = 1'b1
  } req_type_t;

  typedef enum logic {
    KIND_POS   = 1'b0,
    KIND_COUNT = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [31:0] frame_high;
    logic [63:0] frame_low;
    logic [31:0] range_last;
    logic [31:0] range_first;
  } in_data_t;

  typedef struct packed {
    req_type_t req_type;
    in_data_t  data;
  } in_item_t;

  typedef struct packed {
    result_kind_t     kind;
    logic [POS_W-1:0] value;
    logic             last;
  } result_t;

  // Results produced by one transaction, slot0 first.
  typedef struct packed {
    logic [1:0] n;
    result_t    slot0;
    result_t    slot1;
  } push_t;

  function automatic logic [3:0] popcnt8(input logic [CHUNK_W-1:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/hb96s_dist.sv
// Hamming distance of two 96-bit frames against the match threshold.
`timescale 1ns / 1ps
module hb96s_dist
  import hb96s_pkg::*;
(
  input  logic [FRAME_W-1:0] frame,
  input  logic [FRAME_W-1:0] query,
  input  logic [THR_W-1:0]   threshold,
  output logic               is_match
);

  logic [FRAME_W-1:0] diff;
  logic [3:0]         chunk_cnt [N_CHUNKS];
  logic [4:0]         pair_cnt  [N_PAIRS];
  logic [DIST_W-1:0]  ham_dist;

  assign diff = frame ^ query;

  always_comb begin
    for (int i = 0; i < N_CHUNKS; i++) begin
      chunk_cnt[i] = popcnt8(diff[i*CHUNK_W +: CHUNK_W]);
    end
    for (int j = 0; j < N_PAIRS; j++) begin
      pair_cnt[j] = 5'(chunk_cnt[2*j]) + 5'(chunk_cnt[2*j+1]);
    end
  end

  // six-way sum, max 96
  assign ham_dist = ((DIST_W'(pair_cnt[0]) + DIST_W'(pair_cnt[1]))
                   + (DIST_W'(pair_cnt[2]) + DIST_W'(pair_cnt[3])))
                  + (DIST_W'(pair_cnt[4]) + DIST_W'(pair_cnt[5]));

  assign is_match = (ham_dist <= threshold);

endmodule

// File: rtl/core/hb96s_core.sv
// Bucket state, threshold register and per-item result decision.
`timescale 1ns / 1ps
module hb96s_core
  import hb96s_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  in_item_t         item,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_thr,
  output push_t            push
);

  logic [THR_W-1:0]   threshold;
  logic [63:0]        query_low;
  logic [31:0]        query_high;
  logic [POS_W-1:0]   cur_pos;
  logic [POS_W-1:0]   fin_pos;
  logic [POS_W-1:0]   match_count;
  logic               bucket_open;

  logic [63:0]        query_low_next;
  logic [31:0]        query_high_next;
  logic [POS_W-1:0]   cur_pos_next;
  logic [POS_W-1:0]   fin_pos_next;
  logic [POS_W-1:0]   match_count_next;
  logic               bucket_open_next;

  logic               is_match;
  logic               is_end;
  logic [POS_W-1:0]   count_inc;

  hb96s_dist u_dist (
    .frame     ({item.data.frame_high, item.data.frame_low}),
    .query     ({query_high, query_low}),
    .threshold (threshold),
    .is_match  (is_match)
  );

  assign is_end    = (cur_pos == fin_pos);
  assign count_inc = (match_count == '1) ? match_count : match_count + 1'b1;

  always_comb begin
    query_low_next   = query_low;
    query_high_next  = query_high;
    cur_pos_next     = cur_pos;
    fin_pos_next     = fin_pos;
    match_count_next = match_count;
    bucket_open_next = bucket_open;
    push             = '0;
    push.slot0.kind  = KIND_POS;
    push.slot1.kind  = KIND_POS;
    if (fire) begin
      if (item.req_type == REQ_START) begin
        query_low_next   = item.data.frame_low;
        query_high_next  = item.data.frame_high;
        cur_pos_next     = item.data.range_first;
        fin_pos_next     = item.data.range_last;
        match_count_next = '0;
        if (item.data.range_last < item.data.range_first) begin
          // empty range: zero count at once
          bucket_open_next = 1'b0;
          push.n           = 2'd1;
          push.slot0.kind  = KIND_COUNT;
          push.slot0.value = '0;
          push.slot0.last  = 1'b1;
        end else begin
          bucket_open_next = 1'b1;
        end
      end else if (bucket_open) begin
        if (is_match) begin
          match_count_next = count_inc;
          push.slot0.kind  = KIND_POS;
          push.slot0.value = cur_pos;
          push.slot0.last  = !is_end;
        end
        if (is_end) begin
          bucket_open_next = 1'b0;
          if (is_match) begin
            push.n           = 2'd2;
            push.slot1.kind  = KIND_COUNT;
            push.slot1.value = count_inc;
            push.slot1.last  = 1'b1;
          end else begin
            push.n           = 2'd1;
            push.slot0.kind  = KIND_COUNT;
            push.slot0.value = match_count;
            push.slot0.last  = 1'b1;
          end
        end else begin
          cur_pos_next = cur_pos + 1'b1;
          push.n       = is_match ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THR_RESET;
      bucket_open <= 1'b0;
      query_low   <= '0;
      query_high  <= '0;
      cur_pos     <= '0;
      fin_pos     <= '0;
      match_count <= '0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_thr;
      end
      bucket_open <= bucket_open_next;
      query_low   <= query_low_next;
      query_high  <= query_high_next;
      cur_pos     <= cur_pos_next;
      fin_pos     <= fin_pos_next;
      match_count <= match_count_next;
    end
  end

endmodule

// File: rtl/core/hb96s_outq.sv
// Result queue: takes up to two results per cycle, hands out one while m_tready is high.
`timescale 1ns / 1ps
module hb96s_outq
  import hb96s_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic             space_ok,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [POS_W-1:0] m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  localparam logic [OUTQ_CNT_W-1:0] ROOM_LIMIT = OUTQ_CNT_W'(OUTQ_DEPTH - 2);

  result_t               q_mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_CNT_W-1:0] count;
  logic [OUTQ_PTR_W-1:0] wr_ptr_next;
  logic [OUTQ_PTR_W-1:0] rd_ptr_next;
  logic [OUTQ_CNT_W-1:0] count_next;
  logic                  pop;
  result_t               head;

  assign space_ok = (count <= ROOM_LIMIT);
  assign pop      = m_tvalid && m_tready;
  assign head     = q_mem[rd_ptr];

  assign m_tvalid = (count != '0);
  assign m_tdata  = head.value;
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  assign wr_ptr_next = wr_ptr + OUTQ_PTR_W'(push.n);
  assign rd_ptr_next = rd_ptr + OUTQ_PTR_W'(pop);
  assign count_next  = count + OUTQ_CNT_W'(push.n) - OUTQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_mem[wr_ptr] <= push.slot0;
    end
    if (push.n == 2'd2) begin
      q_mem[wr_ptr + 1'b1] <= push.slot1;
    end
  end

endmodule

// File: rtl/core/hamming96_bucket_screen.sv
// Top level of the 96-bit Hamming distance bucket screen.
`timescale 1ns / 1ps
// Screens a bucket of 96-bit frames against a query. A start transaction
// (s_tuser = 0) loads the query and the first/last position numbers; each
// candidate transaction (s_tuser = 1) is XORed with the query, its set bits
// counted and compared with match_threshold (cfg port, reset 10). A match
// emits the position (m_tuser = 0). After the last position the match count
// goes out (m_tuser = 1, m_tlast = 1). An empty range (last < first) gives a
// zero count at once; candidates outside a bucket are dropped, and a start
// inside an open bucket abandons it silently. Rate: one item per clock,
// sustained while the result queue has room. Popcount, compare and the
// bucket state update for the item in the input register happen in the same
// cycle; results are written into a 4-entry queue and show on the m_ side
// behind older ones. The queue takes two results per cycle but drains at most one; the
// item closing a bucket with a match pushes two. Input stalls only when the
// queue holds more than two results. Threshold writes are allowed only while idle.
module hamming96_bucket_screen
  import hb96s_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // input transactions
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [159:0]     s_tdata,   // range_first, range_last, frame_low, frame_high
  input  logic             s_tuser,   // req_type
  // result transactions
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [POS_W-1:0] m_tdata,   // result_value
  output logic             m_tuser,   // result_kind
  output logic             m_tlast,   // last_of_run
  // threshold write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data   // match_threshold
);

  // Input register
  logic     in_valid;
  in_item_t in_item;
  logic     space_ok;
  logic     fire;
  push_t    push;

  assign fire      = in_valid && space_ok;
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type <= req_type_t'(s_tuser);
      in_item.data     <= s_tdata;
    end
  end

  hb96s_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (in_item),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_thr (cfg_data),
    .push    (push)
  );

  hb96s_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/core/hb96s_checker.sv
// Port-level checker for the bucket screen, bound to the top level.
`timescale 1ns / 1ps
`include "hamming96_bucket_screen_macros.svh"
module hb96s_checker
  import hb96s_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [POS_W-1:0] m_tdata,
  input logic             m_tuser,
  input logic             m_tlast,
  input logic             cfg_ready
);

  // a stalled result stays offered
  `HB96S_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // and keeps its contents
  `HB96S_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

  // a count result always closes the run
  `HB96S_ASSERT_IMPL(a_count_last, m_tvalid && (m_tuser == KIND_COUNT), m_tlast, "count without tlast")

  // reset leaves the queue empty and the input open
  `HB96S_ASSERT_ALWAYS(a_reset_idle, rst, s_tready && !m_tvalid, "not idle after reset")

  // threshold port never back-pressures
  `HB96S_ASSERT_IMPL(a_cfg_ready, 1'b1, cfg_ready, "cfg_ready low")

endmodule

bind hamming96_bucket_screen hb96s_checker u_hb96s_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast),
  .cfg_ready (cfg_ready)
);

// File: bench/hamming96_bucket_screen_tb.sv
// Self-checking testbench for the 96-bit Hamming distance bucket screen.
`timescale 1ns / 1ps
module hamming96_bucket_screen_tb;
  import hb96s_pkg::*;

  // One expected result transaction on the m_ side.
  typedef struct {
    result_kind_t kind;
    logic [31:0]  value;
    logic         last;
  } screen_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;   // range_first, range_last, frame_low, frame_high
  logic         s_tuser;   // req_type
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;   // result_value
  logic         m_tuser;   // result_kind
  logic         m_tlast;   // last_of_run
  logic         cfg_valid;
  logic         cfg_ready;
  logic [6:0]   cfg_data;  // match_threshold

  // Shadow state of the screen, advanced on every accepted input transaction.
  logic [6:0]   thr_now     = THR_RESET;
  logic [95:0]  query_frame = '0;
  logic [31:0]  pos_now     = '0;
  logic [31:0]  pos_final   = '0;
  logic [31:0]  hit_count   = '0;
  logic         bucket_live = 1'b0;

  screen_result_t pending_results[$];
  screen_result_t seen_exp;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int n_accepted    = 0;
  int n_checked     = 0;
  int n_positions   = 0;
  int n_counts      = 0;
  int n_thr_writes  = 0;

  hamming96_bucket_screen dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // Receiver back-pressure, redrawn every cycle.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  function automatic void push_result(result_kind_t kind, logic [31:0] value, logic last);
    screen_result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = last;
    pending_results.push_back(r);
    if (kind == KIND_POS) n_positions++;
    else n_counts++;
  endfunction

  // Predicts the results of one accepted input transaction.
  function automatic void screen_predict(req_type_t req, logic [159:0] d);
    logic [31:0] first;
    logic [31:0] last;
    logic [95:0] frame;
    int          ham;
    logic        at_end;
    first = d[31:0];
    last  = d[63:32];
    frame = d[159:64];
    if (req == REQ_START) begin
      query_frame = frame;
      pos_now     = first;
      pos_final   = last;
      hit_count   = '0;
      // empty range: zero count right away, bucket stays closed
      if (last < first) begin
        bucket_live = 1'b0;
        push_result(KIND_COUNT, 32'd0, 1'b1);
      end else begin
        bucket_live = 1'b1;
      end
    end else if (bucket_live) begin
      ham    = $countones(frame ^ query_frame);
      at_end = (pos_now == pos_final);
      if (ham <= int'(thr_now)) begin
        push_result(KIND_POS, pos_now, !at_end);
        if (hit_count != 32'hFFFF_FFFF) hit_count = hit_count + 1;
      end
      if (at_end) begin
        push_result(KIND_COUNT, hit_count, 1'b1);
        bucket_live = 1'b0;
      end else begin
        pos_now = pos_now + 1;
      end
    end
  endfunction

  function automatic logic [95:0] rand96();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Query with exactly k distinct bits flipped.
  function automatic logic [95:0] frame_at_distance(logic [95:0] q, int k);
    logic [95:0] m;
    m = '0;
    while ($countones(m) < k) m[$urandom_range(95, 0)] = 1'b1;
    return q ^ m;
  endfunction

  // Sends one transaction; returns right after the accepting edge with
  // s_tvalid still high, so back-to-back items keep it high.
  task automatic send_request(req_type_t req, logic [31:0] first, logic [31:0] last,
                              logic [95:0] frame);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {frame, last, first};
    do @(posedge clk); while (!s_tready);
    n_accepted++;
    screen_predict(req, {frame, last, first});
  endtask

  task automatic drop_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Threshold write only while idle; a dropped candidate may still be in the
  // input register, so give the pipeline time to clear it first.
  task automatic write_threshold(logic [6:0] v);
    wait_results_drained();
    repeat (6) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    thr_now = v;
    n_thr_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset threshold: boundary distances, wrap-free top position, a match on
  // the closing candidate, an empty range, dropped and abandoned buckets.
  task automatic test_bucket_basics();
    send_request(REQ_CAND, '0, '0, '1);                      // no bucket yet: dropped
    send_request(REQ_START, 32'd5, 32'd7, '0);
    send_request(REQ_CAND, '0, '0, '0);                      // distance 0
    send_request(REQ_CAND, '0, '0, 96'h3FF);                 // distance 10 = threshold
    send_request(REQ_CAND, '0, '0, 96'h7FF);                 // distance 11, last position
    wait_results_drained();                                  // sender holds off here
    send_request(REQ_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    send_request(REQ_CAND, '0, '0, '1);                      // match on the closing item
    send_request(REQ_CAND, '0, '0, '1);                      // bucket closed: dropped
    send_request(REQ_START, 32'h8000_0000, 32'h7FFF_FFFF, rand96()); // empty range
    send_request(REQ_START, 32'h0000_0000, 32'hFFFF_FFFF, 96'h5A5A);
    send_request(REQ_CAND, '0, '0, 96'h5A5A);
    // abandons the open full-width bucket without a count
    send_request(REQ_START, 32'hFFFF_FFFE, 32'hFFFF_FFFF, '0);
    send_request(REQ_CAND, '0, '0, '1);                      // distance 96
    send_request(REQ_CAND, '0, '0, '0);                      // ends at the top, no wrap
  endtask

  task automatic test_threshold_extremes();
    logic [95:0] q;
    q = rand96();
    write_threshold(7'd0);
    send_request(REQ_START, 32'd1, 32'd2, q);
    send_request(REQ_CAND, '0, '0, q);
    send_request(REQ_CAND, '0, '0, frame_at_distance(q, 1));
    write_threshold(7'd127);                                 // above 96: all match
    send_request(REQ_START, 32'd10, 32'd11, '0);
    send_request(REQ_CAND, '0, '0, '1);
    send_request(REQ_CAND, '0, '0, rand96());
    write_threshold(7'd96);
    send_request(REQ_START, 32'd3, 32'd3, '0);
    send_request(REQ_CAND, '0, '0, '1);
  endtask

  // Mostly complete buckets with frames near the threshold, plus empty
  // ranges, cut-short buckets and stray candidates.
  task automatic test_random_buckets(int n_items);
    int          sent;
    int          len;
    int          n_cand;
    int          k;
    int          sel;
    logic [31:0] first;
    logic [31:0] last;
    logic [95:0] q;
    logic [95:0] f;
    logic [6:0]  thr;
    sent = 0;
    case ($urandom_range(5, 0))
      0: thr = 7'd0;
      1: thr = 7'd96;
      2: thr = 7'd127;
      3: thr = THR_RESET;
      default: thr = 7'($urandom_range(24, 0));
    endcase
    write_threshold(thr);
    while (sent < n_items) begin
      sel = $urandom_range(99, 0);
      if (sel < 5) begin
        // stray candidate: ignored unless a cut-short bucket is still open
        send_request(REQ_CAND, $urandom, $urandom, rand96());
      end else if (sel < 10) begin
        first = $urandom_range(32'hFFFF_FFFF, 1);
        last  = $urandom_range(first - 1, 0);
        send_request(REQ_START, first, last, rand96());
        sent++;
      end else begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        first = $urandom;
        if ($urandom_range(9, 0) == 0 || first > 32'hFFFF_FFFF - (len - 1))
          first = 32'hFFFF_FFFF - (len - 1);
        last = first + (len - 1);
        case ($urandom_range(9, 0))
          0: q = '0;
          1: q = '1;
          default: q = rand96();
        endcase
        // a cut-short bucket is abandoned by the next start
        n_cand = (sel < 15) ? $urandom_range(len - 1, 0) : len;
        send_request(REQ_START, first, last, q);
        sent++;
        repeat (n_cand) begin
          sel = $urandom_range(9, 0);
          if (sel < 5) begin
            k = int'(thr_now) + int'($urandom_range(4, 0)) - 2;
            if (k < 0) k = 0;
            if (k > 96) k = 96;
          end else if (sel < 8) begin
            k = $urandom_range(96, 0);
          end else begin
            k = 0;
          end
          f = (sel == 9) ? rand96() : frame_at_distance(q, k);
          send_request(REQ_CAND, $urandom, $urandom, f);
          sent++;
        end
      end
      if ($urandom_range(99, 0) < 3) wait_results_drained();
    end
  endtask

  // Result checker: every m_ transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d value %h last %0d",
                 $time, m_tuser, m_tdata, m_tlast);
        fail_count++;
      end else begin
        seen_exp = pending_results.pop_front();
        n_checked++;
        if (m_tuser !== seen_exp.kind) begin
          $display("%0t: result_kind mismatch: expected %0d, got %0d",
                   $time, seen_exp.kind, m_tuser);
          fail_count++;
        end
        if (m_tdata !== seen_exp.value) begin
          $display("%0t: result_value mismatch: expected %h, got %h",
                   $time, seen_exp.value, m_tdata);
          fail_count++;
        end
        if (m_tlast !== seen_exp.last) begin
          $display("%0t: last_of_run mismatch: expected %0d, got %0d",
                   $time, seen_exp.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 36;
    recv_idle_pct = 63;
    test_bucket_basics();
    test_threshold_extremes();
    test_random_buckets(100);
    test_random_buckets(100);

    send_idle_pct = 63;
    recv_idle_pct = 36;
    test_random_buckets(100);
    test_random_buckets(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_buckets(100);
    test_random_buckets(100);

    wait_results_drained();
    repeat (10) @(posedge clk);

    $display("Covered %0d input transactions and %0d results (%0d positions, %0d counts).",
             n_accepted, n_checked, n_positions, n_counts);
    $display("Threshold written %0d times incl. 0, 96 and 127; idle mixes 36/63, 63/36, none.",
             n_thr_writes);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
